[rtl/ssel_pkg.sv]
// shared types and constants for the shadow stack event logger
package ssel_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_BRANCH_TAG   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POP_TAG      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INDIRECT_TAG = 2'd2;

    localparam logic [7:0] BRANCH_TAG_RST   = 8'd1;
    localparam logic [7:0] POP_TAG_RST      = 8'd2;
    localparam logic [7:0] INDIRECT_TAG_RST = 8'd3;

    localparam logic [2:0] OP_INIT     = 3'd0;
    localparam logic [2:0] OP_BRANCH   = 3'd1;
    localparam logic [2:0] OP_PUSH     = 3'd2;
    localparam logic [2:0] OP_POP      = 3'd3;
    localparam logic [2:0] OP_INDIRECT = 3'd4;
    localparam logic [2:0] OP_READ     = 3'd5;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_OVERFLOW = 3'd1;
    localparam logic [2:0] ST_SECURITY = 3'd2;
    localparam logic [2:0] ST_SHORT    = 3'd3;
    localparam logic [2:0] ST_BAD      = 3'd4;

    localparam logic [3:0] MAX_PAYLOAD = 4'd8;
    localparam logic [3:0] POP_BYTES   = 4'd4;
    localparam logic [3:0] IND_BYTES   = 4'd8;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [63:0] value;
        logic [3:0]  payload_length;
        logic [13:0] read_capacity;
        logic [12:0] read_index;
    } ssel_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        log_dropped;
        logic [7:0]  log_byte;
        logic [13:0] log_length;
    } ssel_result_t;

    typedef struct packed {
        logic       load;
        logic       init;
        logic       push;
        logic       pop;
        logic       log_wr;
        logic       rd_issue;
        logic       take_byte;
        logic       set_status;
        logic [2:0] status;
        logic       set_drop;
    } ssel_cmd_t;

    typedef struct packed {
        logic [2:0] opcode;
        logic       started;
        logic       plen_bad;
        logic       room_ok;
        logic       stack_full;
        logic       stack_empty;
        logic       short_buf;
        logic       idx_ok;
        logic       pop_match;
        logic       log_last;
    } ssel_stat_t;

endpackage

[rtl/ssel_dp.sv]
// datapath: item registers, shadow stack, event log memory and result registers
module ssel_dp #(
    parameter int STACK_DEPTH = 128,
    parameter int LOG_BYTES   = 8192
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  ssel_pkg::ssel_item_t               item,
    input  logic                               cfg_we,
    input  logic [ssel_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ssel_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  ssel_pkg::ssel_cmd_t                cmd,
    output ssel_pkg::ssel_stat_t               stat,
    output ssel_pkg::ssel_result_t             result
);

    localparam int SD_W   = $clog2(STACK_DEPTH + 1);
    localparam int SI_W   = $clog2(STACK_DEPTH);
    localparam int LOG_AW = $clog2(LOG_BYTES);
    localparam int FILL_W = $clog2(LOG_BYTES + 1);
    localparam int CMP_W  = FILL_W + 1;
    localparam int RW     = (FILL_W > 14) ? FILL_W : 14;

    logic [31:0] stack_mem [STACK_DEPTH];
    logic [7:0]  log_mem [LOG_BYTES];

    logic [7:0]        branch_tag_reg, pop_tag_reg, indirect_tag_reg;
    logic [SD_W-1:0]   depth_reg, depth_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              started_reg, started_next;
    logic [3:0]        cnt_reg, cnt_next;

    logic [2:0]  op_reg;
    logic [63:0] data_reg;
    logic [3:0]  plen_reg;
    logic [13:0] cap_reg;
    logic [12:0] ridx_reg;
    logic [2:0]  status_reg;
    logic        drop_reg;
    logic [7:0]  byte_reg;
    logic [31:0] stk_rd_reg;
    logic [7:0]  log_rd_reg;

    logic [SD_W-1:0]  depth_dec;
    logic [3:0]       rec_len;
    logic [7:0]       rec_tag;
    logic [7:0]       log_wdata;
    logic [CMP_W-1:0] room_sum;
    logic [RW-1:0]    fill_ext, cap_ext, ridx_ext;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            branch_tag_reg   <= ssel_pkg::BRANCH_TAG_RST;
            pop_tag_reg      <= ssel_pkg::POP_TAG_RST;
            indirect_tag_reg <= ssel_pkg::INDIRECT_TAG_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ssel_pkg::CFG_BRANCH_TAG:   branch_tag_reg   <= cfg_wdata;
                ssel_pkg::CFG_POP_TAG:      pop_tag_reg      <= cfg_wdata;
                ssel_pkg::CFG_INDIRECT_TAG: indirect_tag_reg <= cfg_wdata;
                default:                    ;
            endcase
        end
    end

    assign depth_dec = depth_reg - SD_W'(1);

    always_comb
    begin
        priority if (op_reg == ssel_pkg::OP_BRANCH)
        begin
            rec_len = plen_reg;
            rec_tag = branch_tag_reg;
        end
        else if (op_reg == ssel_pkg::OP_POP)
        begin
            rec_len = ssel_pkg::POP_BYTES;
            rec_tag = pop_tag_reg;
        end
        else
        begin
            rec_len = ssel_pkg::IND_BYTES;
            rec_tag = indirect_tag_reg;
        end
    end

    assign room_sum  = CMP_W'(fill_reg) + CMP_W'(1) + CMP_W'(rec_len);
    assign log_wdata = (cnt_reg == 4'd0) ? rec_tag : data_reg[7:0];
    assign fill_ext  = RW'(fill_reg);
    assign cap_ext   = RW'(cap_reg);
    assign ridx_ext  = RW'(ridx_reg);

    always_comb
    begin
        depth_next = depth_reg;
        if (cmd.init)
            depth_next = '0;
        else if (cmd.push)
            depth_next = depth_reg + SD_W'(1);
        else if (cmd.pop)
            depth_next = depth_dec;

        fill_next = fill_reg;
        if (cmd.init)
            fill_next = '0;
        else if (cmd.log_wr)
            fill_next = fill_reg + FILL_W'(1);

        started_next = started_reg | cmd.init;

        cnt_next = cnt_reg;
        if (cmd.load)
            cnt_next = 4'd0;
        else if (cmd.log_wr)
            cnt_next = cnt_reg + 4'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg   <= '0;
            fill_reg    <= '0;
            started_reg <= 1'b0;
            cnt_reg     <= 4'd0;
        end
        else
        begin
            depth_reg   <= depth_next;
            fill_reg    <= fill_next;
            started_reg <= started_next;
            cnt_reg     <= cnt_next;
        end
    end

    // latched word and result fields
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= item.opcode;
            data_reg   <= item.value;
            plen_reg   <= item.payload_length;
            cap_reg    <= item.read_capacity;
            ridx_reg   <= item.read_index;
            status_reg <= ssel_pkg::ST_OK;
            drop_reg   <= 1'b0;
            byte_reg   <= 8'd0;
        end
        else
        begin
            if (cmd.log_wr && cnt_reg != 4'd0)
                data_reg <= {8'd0, data_reg[63:8]};
            if (cmd.set_status)
                status_reg <= cmd.status;
            if (cmd.set_drop)
                drop_reg <= 1'b1;
            if (cmd.take_byte)
                byte_reg <= log_rd_reg;
        end
    end

    // shadow stack memory
    always_ff @(posedge clk)
    begin
        if (cmd.push)
            stack_mem[depth_reg[SI_W-1:0]] <= data_reg[31:0];
        if (cmd.pop)
            stk_rd_reg <= stack_mem[depth_dec[SI_W-1:0]];
    end

    // event log memory
    always_ff @(posedge clk)
    begin
        if (cmd.log_wr)
            log_mem[fill_reg[LOG_AW-1:0]] <= log_wdata;
        if (cmd.rd_issue)
            log_rd_reg <= log_mem[ridx_ext[LOG_AW-1:0]];
    end

    always_comb
    begin
        stat.opcode      = op_reg;
        stat.started     = started_reg;
        stat.plen_bad    = plen_reg > ssel_pkg::MAX_PAYLOAD;
        stat.room_ok     = room_sum <= CMP_W'(LOG_BYTES);
        stat.stack_full  = depth_reg == SD_W'(STACK_DEPTH);
        stat.stack_empty = depth_reg == '0;
        stat.short_buf   = cap_ext < fill_ext;
        stat.idx_ok      = (ridx_ext < fill_ext) && (ridx_ext < RW'(LOG_BYTES));
        stat.pop_match   = stk_rd_reg == data_reg[31:0];
        stat.log_last    = cnt_reg == rec_len;
    end

    assign result.status      = status_reg;
    assign result.log_dropped = drop_reg;
    assign result.log_byte    = byte_reg;
    assign result.log_length  = fill_ext[13:0];

endmodule

[rtl/ssel_ctrl.sv]
// controller state machine that sequences one word through the datapath
module ssel_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  ssel_pkg::ssel_stat_t stat,
    output ssel_pkg::ssel_cmd_t  cmd,
    output logic                 busy,
    output logic                 done
);

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_EXEC    = 6'b000010,
        S_POP_CHK = 6'b000100,
        S_LOG     = 6'b001000,
        S_READ    = 6'b010000,
        S_DONE    = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.status = ssel_pkg::ST_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_DONE;
                unique case (stat.opcode)
                    ssel_pkg::OP_INIT:
                        cmd.init = 1'b1;
                    ssel_pkg::OP_BRANCH:
                    begin
                        if (!stat.started || stat.plen_bad)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ssel_pkg::ST_BAD;
                        end
                        else if (stat.room_ok)
                            state_next = S_LOG;
                        else
                            cmd.set_drop = 1'b1;
                    end
                    ssel_pkg::OP_PUSH:
                    begin
                        if (stat.stack_full)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ssel_pkg::ST_OVERFLOW;
                        end
                        else
                            cmd.push = 1'b1;
                    end
                    ssel_pkg::OP_POP:
                    begin
                        if (stat.stack_empty)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ssel_pkg::ST_SECURITY;
                        end
                        else
                        begin
                            cmd.pop    = 1'b1;
                            state_next = S_POP_CHK;
                        end
                    end
                    ssel_pkg::OP_INDIRECT:
                    begin
                        if (stat.room_ok)
                            state_next = S_LOG;
                        else
                            cmd.set_drop = 1'b1;
                    end
                    ssel_pkg::OP_READ:
                    begin
                        if (stat.short_buf)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status     = ssel_pkg::ST_SHORT;
                        end
                        else if (stat.idx_ok)
                        begin
                            cmd.rd_issue = 1'b1;
                            state_next   = S_READ;
                        end
                    end
                    default:
                    begin
                        cmd.set_status = 1'b1;
                        cmd.status     = ssel_pkg::ST_BAD;
                    end
                endcase
            end
            S_POP_CHK:
            begin
                state_next = S_DONE;
                if (!stat.pop_match)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ssel_pkg::ST_SECURITY;
                end
                else if (stat.room_ok)
                    state_next = S_LOG;
                else
                    cmd.set_drop = 1'b1;
            end
            S_LOG:
            begin
                cmd.log_wr = 1'b1;
                if (stat.log_last)
                    state_next = S_DONE;
            end
            S_READ:
            begin
                cmd.take_byte = 1'b1;
                state_next    = S_DONE;
            end
            S_DONE:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = state_reg != S_IDLE;
    assign done = state_reg == S_DONE;

endmodule

[rtl/shadow_stack_event_logger.sv]
// top level of the shadow stack event logger
// A word is taken when start is high and busy is low; busy stays high until the
// cycle after its result. The result shows on result for exactly one cycle with
// done high and must be taken then, since the receiver cannot stall the block.
// From accept the controller passes through EXEC and DONE back to IDLE for init,
// push, errors, dropped records and reads that return no byte; a read that returns
// a byte also passes READ, and a branch record or indirect call stays in LOG for
// each logged byte (tag plus payload, up to 9): the event log is one byte wide, so
// its bytes are written one at a time. A pop on a non-empty stack also passes
// POP_CHK, reading the shadow stack before its compare, and then LOG once logged.
// Both memories come out of reset unwritten and need no clearing pass.
module shadow_stack_event_logger #(
    parameter int STACK_DEPTH = 128,
    parameter int LOG_BYTES   = 8192
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  ssel_pkg::ssel_item_t            item,
    output logic                            done,
    output ssel_pkg::ssel_result_t          result,
    input  logic                            cfg_we,
    input  logic [ssel_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ssel_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    ssel_pkg::ssel_cmd_t  cmd;
    ssel_pkg::ssel_stat_t stat;

    ssel_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    ssel_dp #(
        .STACK_DEPTH (STACK_DEPTH),
        .LOG_BYTES   (LOG_BYTES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat),
        .result    (result)
    );

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted word did not raise busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done && !busy)
        else $error("result strobe longer than one cycle");

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result while idle");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.status <= ssel_pkg::ST_BAD)
        else $error("status code out of range");

    a_pop_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.push && cmd.pop) && !(cmd.log_wr && cmd.init))
        else $error("conflicting datapath commands");

endmodule

[tb/shadow_stack_event_logger_checker.sv]
// checker for the shadow stack event logger: predicts each result word and compares it
module shadow_stack_event_logger_checker
    import ssel_pkg::*;
#(
    parameter int STACK_DEPTH = 128,
    parameter int LOG_BYTES   = 8192
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  ssel_item_t            item,
    input  logic                  done,
    input  ssel_result_t          result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                    mismatch_count,
    output int                    words_pending,
    output logic [13:0]           model_fill
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [7:0]   branch_tag_q;
    logic [7:0]   pop_tag_q;
    logic [7:0]   indirect_tag_q;
    logic [31:0]  ret_stack [STACK_DEPTH];
    int           stack_top;
    logic [7:0]   event_bytes [LOG_BYTES];
    int           fill_count;
    bit           session_open;
    ssel_result_t expected_words [$];

    function automatic logic log_append(input logic [7:0] tag, input logic [63:0] data,
                                        input int nbytes);
        if (fill_count + 1 + nbytes > LOG_BYTES)
            return 1'b1;
        event_bytes[fill_count] = tag;
        fill_count++;
        for (int i = 0; i < nbytes; i++)
        begin
            event_bytes[fill_count] = data[8*i +: 8];
            fill_count++;
        end
        return 1'b0;
    endfunction

    function automatic ssel_result_t predict_logger_word(input ssel_item_t w);
        ssel_result_t r;
        r = '0;
        case (w.opcode)
            OP_INIT:
            begin
                stack_top    = 0;
                fill_count   = 0;
                session_open = 1'b1;
            end
            OP_BRANCH:
            begin
                if (!session_open || w.payload_length > MAX_PAYLOAD)
                    r.status = ST_BAD;
                else
                    r.log_dropped = log_append(branch_tag_q, w.value, int'(w.payload_length));
            end
            OP_PUSH:
            begin
                if (stack_top >= STACK_DEPTH)
                    r.status = ST_OVERFLOW;
                else
                begin
                    ret_stack[stack_top] = w.value[31:0];
                    stack_top++;
                end
            end
            OP_POP:
            begin
                if (stack_top == 0)
                    r.status = ST_SECURITY;
                else
                begin
                    // a mismatched entry stays popped
                    stack_top--;
                    if (ret_stack[stack_top] != w.value[31:0])
                        r.status = ST_SECURITY;
                    else
                        r.log_dropped = log_append(pop_tag_q, {32'd0, w.value[31:0]},
                                                   int'(POP_BYTES));
                end
            end
            OP_INDIRECT:
                r.log_dropped = log_append(indirect_tag_q, w.value, int'(IND_BYTES));
            OP_READ:
            begin
                if (int'(w.read_capacity) < fill_count)
                    r.status = ST_SHORT;
                else if (int'(w.read_index) < fill_count)
                    r.log_byte = event_bytes[w.read_index];
            end
            default:
                r.status = ST_BAD;
        endcase
        r.log_length = fill_count[13:0];
        return r;
    endfunction

    task automatic report_word(input string why, input ssel_result_t want,
                               input ssel_result_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s: expected status %0d dropped %0d byte %02h length %0d, got %0d %0d %02h %0d",
                     why, want.status, want.log_dropped, want.log_byte, want.log_length,
                     got.status, got.log_dropped, got.log_byte, got.log_length);
    endtask

    always @(posedge clk)
    begin : watch
        ssel_result_t want;
        if (!rst_n)
        begin
            branch_tag_q   = BRANCH_TAG_RST;
            pop_tag_q      = POP_TAG_RST;
            indirect_tag_q = INDIRECT_TAG_RST;
            stack_top      = 0;
            fill_count     = 0;
            session_open   = 1'b0;
            mismatch_count = 0;
            expected_words.delete();
        end
        else
        begin
            if (done)
            begin
                if (expected_words.size() == 0)
                    report_word("unexpected result word", '0, result);
                else
                begin
                    want = expected_words.pop_front();
                    if (result.status !== want.status || result.log_dropped !== want.log_dropped ||
                        result.log_byte !== want.log_byte || result.log_length !== want.log_length)
                        report_word("result word mismatch", want, result);
                end
            end
            if (start && !busy)
                expected_words.push_back(predict_logger_word(item));
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_BRANCH_TAG:   branch_tag_q   = cfg_wdata;
                    CFG_POP_TAG:      pop_tag_q      = cfg_wdata;
                    CFG_INDIRECT_TAG: indirect_tag_q = cfg_wdata;
                    default: ;
                endcase
            end
        end
        words_pending <= expected_words.size();
        model_fill    <= fill_count[13:0];
    end

endmodule

[tb/shadow_stack_event_logger_test.sv]
// testbench top for the shadow stack event logger: stimulus, tag settings and verdict
module shadow_stack_event_logger_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ssel_pkg::*;

    localparam int STACK_DEPTH    = 128;
    localparam int LOG_BYTES      = 8192;
    localparam int WATCHDOG_LIMIT = 2000;

    localparam logic [2:0]           OP_UNUSED_A = 3'd6;
    localparam logic [2:0]           OP_UNUSED_B = 3'd7;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;

    typedef enum int {MIX_BALANCED, MIX_PUSH, MIX_POP, MIX_READ, MIX_FILL} word_mix_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    ssel_item_t            in_word = '0;
    logic                  done;
    ssel_result_t          out_word;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int          mismatches;
    int          words_pending;
    logic [13:0] model_fill;

    bit          idle_on = 1'b1;
    logic [31:0] pushed_addrs [$];
    int          stall_cycles = 0;
    int          full_words = 0;

    always #6 clk = ~clk;

    shadow_stack_event_logger #(
        .STACK_DEPTH (STACK_DEPTH),
        .LOG_BYTES   (LOG_BYTES)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (in_word),
        .done      (done),
        .result    (out_word),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    shadow_stack_event_logger_checker #(
        .STACK_DEPTH (STACK_DEPTH),
        .LOG_BYTES   (LOG_BYTES)
    ) checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .item           (in_word),
        .done           (done),
        .result         (out_word),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .mismatch_count (mismatches),
        .words_pending  (words_pending),
        .model_fill     (model_fill)
    );

    function automatic ssel_item_t word_of(input logic [2:0] op, input logic [63:0] value,
                                           input logic [3:0] plen, input logic [13:0] cap,
                                           input logic [12:0] idx);
        ssel_item_t w;
        w.opcode         = op;
        w.value          = value;
        w.payload_length = plen;
        w.read_capacity  = cap;
        w.read_index     = idx;
        return w;
    endfunction

    function automatic logic [2:0] pick_op(input word_mix_t mix);
        int         weights [7];
        logic [2:0] op_order [7];
        int         roll;
        int         acc;
        op_order = '{OP_INIT, OP_BRANCH, OP_PUSH, OP_POP, OP_INDIRECT, OP_READ, OP_UNUSED_A};
        case (mix)
            MIX_PUSH: weights = '{0, 1, 95, 1, 1, 2, 0};
            MIX_POP:  weights = '{1, 8, 20, 55, 4, 10, 2};
            MIX_READ: weights = '{2, 15, 10, 10, 8, 53, 2};
            MIX_FILL: weights = '{0, 12, 6, 6, 70, 6, 0};
            default:  weights = '{3, 20, 22, 22, 10, 20, 3};
        endcase
        roll = $urandom_range(0, 99);
        acc  = 0;
        for (int k = 0; k < 7; k++)
        begin
            acc += weights[k];
            if (roll < acc)
            begin
                if (op_order[k] == OP_UNUSED_A && $urandom_range(0, 1) == 1)
                    return OP_UNUSED_B;
                return op_order[k];
            end
        end
        return OP_READ;
    endfunction

    function automatic ssel_item_t random_word(input word_mix_t mix);
        ssel_item_t w;
        int         fill;
        fill             = int'(model_fill);
        w.opcode         = pick_op(mix);
        w.value          = {$urandom, $urandom};
        w.payload_length = 4'($urandom_range(0, 15));
        w.read_capacity  = 14'($urandom_range(0, 16383));
        w.read_index     = 13'($urandom_range(0, 8191));
        case (w.opcode)
            OP_BRANCH:
            begin
                if ($urandom_range(0, 9) != 0)
                    w.payload_length = 4'($urandom_range(0, 8));
            end
            OP_POP:
            begin
                // mostly a return to the latest pushed address
                if (pushed_addrs.size() > 0 && $urandom_range(0, 99) < 85)
                    w.value[31:0] = pushed_addrs[$];
            end
            OP_READ:
            begin
                case ($urandom_range(0, 9))
                    0, 1: ;
                    2: if (fill > 0) w.read_capacity = 14'(fill - 1);
                    3: w.read_capacity = 14'(fill);
                    default: w.read_capacity = 14'($urandom_range(fill, 16383));
                endcase
                case ($urandom_range(0, 7))
                    0: ;
                    1: if (fill < LOG_BYTES) w.read_index = 13'(fill);
                    default: if (fill > 0) w.read_index = 13'($urandom_range(0, fill - 1));
                endcase
            end
            default: ;
        endcase
        return w;
    endfunction

    task automatic send_word(input ssel_item_t w);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 12);
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start   <= 1'b1;
        in_word <= w;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        case (w.opcode)
            OP_INIT: pushed_addrs.delete();
            OP_PUSH: if (pushed_addrs.size() < STACK_DEPTH) pushed_addrs.push_back(w.value[31:0]);
            OP_POP:  if (pushed_addrs.size() > 0) void'(pushed_addrs.pop_back());
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic run_mix(input word_mix_t mix, input int count);
        repeat (count) send_word(random_word(mix));
    endtask

    task automatic apply_tags(input logic [7:0] br, input logic [7:0] pp, input logic [7:0] ind);
        start <= 1'b0;
        do
            @(negedge clk);
        while (words_pending != 0 || busy !== 1'b0);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_BRANCH_TAG;
        cfg_wdata <= br;
        @(negedge clk);
        cfg_index <= CFG_POP_TAG;
        cfg_wdata <= pp;
        @(negedge clk);
        cfg_index <= CFG_INDIRECT_TAG;
        cfg_wdata <= ind;
        @(negedge clk);
        cfg_index <= CFG_UNUSED;
        cfg_wdata <= 8'($urandom);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        while (stall_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (start && !busy) || done)
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("shadow_stack_event_logger_test NOT OK");
        $finish;
    end

    initial
    begin
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset tags, branch before init, empty pop, bad opcodes
        send_word(word_of(OP_BRANCH, '1, 4'd8, 14'd0, 13'd0));
        send_word(word_of(OP_POP, 64'd0, 4'd0, 14'd0, 13'd0));
        send_word(word_of(OP_READ, 64'd0, 4'd0, 14'd0, 13'd0));
        send_word(word_of(OP_UNUSED_A, '1, 4'hF, '1, '1));
        send_word(word_of(OP_UNUSED_B, 64'd0, 4'd0, 14'd0, 13'd0));
        send_word(word_of(OP_INIT, '1, 4'hF, '1, '1));
        send_word(word_of(OP_BRANCH, '1, 4'd0, 14'd0, 13'd0));
        send_word(word_of(OP_BRANCH, 64'h0123_4567_89ab_cdef, 4'd8, 14'd0, 13'd0));
        send_word(word_of(OP_BRANCH, '1, 4'd9, 14'd0, 13'd0));
        send_word(word_of(OP_BRANCH, '1, 4'hF, 14'd0, 13'd0));
        send_word(word_of(OP_PUSH, '1, 4'd0, 14'd0, 13'd0));
        send_word(word_of(OP_PUSH, 64'hffff_ffff_0000_0000, 4'd0, 14'd0, 13'd0));
        send_word(word_of(OP_POP, 64'd0, 4'd0, 14'd0, 13'd0));
        send_word(word_of(OP_POP, 64'h1234_5678, 4'd0, 14'd0, 13'd0));
        send_word(word_of(OP_POP, '1, 4'd0, 14'd0, 13'd0));
        send_word(word_of(OP_INDIRECT, '1, 4'd0, 14'd0, 13'd0));
        send_word(word_of(OP_INDIRECT, 64'd0, 4'd0, 14'd0, 13'd0));
        send_word(word_of(OP_READ, 64'd0, 4'd0, 14'd0, 13'd0));
        send_word(word_of(OP_READ, 64'd0, 4'd0, 14'(model_fill - 1), 13'd0));
        send_word(word_of(OP_READ, 64'd0, 4'd0, 14'(model_fill), 13'(model_fill - 1)));
        send_word(word_of(OP_READ, 64'd0, 4'd0, '1, '1));
        send_word(word_of(OP_READ, 64'd0, 4'd0, '1, 13'd0));

        apply_tags(8'h00, 8'hff, 8'h80);
        run_mix(MIX_BALANCED, 60);
        apply_tags(8'hff, 8'h00, 8'h7f);
        run_mix(MIX_PUSH, 150);
        run_mix(MIX_POP, 60);
        apply_tags(8'($urandom), 8'($urandom), 8'($urandom));
        run_mix(MIX_READ, 30);
        run_mix(MIX_BALANCED, 20);

        // fill the log to the top and keep going past it
        apply_tags(8'ha5, 8'h5a, 8'hff);
        send_word(word_of(OP_INIT, 64'd0, 4'd0, 14'd0, 13'd0));
        while (int'(model_fill) < LOG_BYTES - 100)
            send_word(word_of(OP_INDIRECT, {$urandom, $urandom}, 4'd0, 14'd0, 13'd0));
        while (full_words < 40)
        begin
            send_word(random_word(MIX_FILL));
            if (int'(model_fill) > LOG_BYTES - 10)
                full_words++;
        end

        idle_on = 1'b0;
        apply_tags(8'($urandom), 8'($urandom), 8'($urandom));
        run_mix(MIX_BALANCED, 40);
        start <= 1'b0;

        do
            @(negedge clk);
        while (words_pending != 0);
        repeat (20) @(negedge clk);
        if (mismatches == 0)
            $display("shadow_stack_event_logger_test OK");
        else
            $display("shadow_stack_event_logger_test NOT OK");
        $finish;
    end

endmodule

[files.f]
rtl/ssel_pkg.sv
rtl/ssel_dp.sv
rtl/ssel_ctrl.sv
rtl/shadow_stack_event_logger.sv
tb/shadow_stack_event_logger_checker.sv
tb/shadow_stack_event_logger_test.sv
